### rtl/fhl_pkg.sv
// Shared types and constants of the frozen-hot LRU replacement block.
package fhl_pkg;

   localparam int FHL_ENTRIES  = 64;
   localparam int FHL_KEY_BITS = 64;

   localparam int ID_W       = 64;
   localparam int SIZE_W     = 32;
   localparam int CAP_W      = 32;
   localparam int FC_W       = 7;
   localparam int OCC_W      = 33;
   localparam int ACC_W      = 34;
   localparam int EVC_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 32'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY     = 1'b0,
      CSR_FROZEN_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [FC_W-1:0]  frozen_count;
   } cfg_type;

   // packed with hit in bit 0
   typedef struct packed {
      logic             frozen_mode;
      logic [EVC_W-1:0] evicted_count;
      logic             inserted;
      logic             frozen_hit;
      logic             hit;
   } rsp_type;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOOK   = 9'b000000010,
      S_PROMO  = 9'b000000100,
      S_EVCHK  = 9'b000001000,
      S_EVICT  = 9'b000010000,
      S_INS    = 9'b000100000,
      S_FRZCHK = 9'b001000000,
      S_FRZ    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

endpackage

### rtl/fhl_engine.sv
// Replacement engine: entry memory, per-entry flags and the sweep sequencer.
module fhl_engine #(
   parameter int ENTRIES  = fhl_pkg::FHL_ENTRIES,
   parameter int KEY_BITS = fhl_pkg::FHL_KEY_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fhl_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KEY_BITS-1:0]       req_key,
   input  logic [fhl_pkg::SIZE_W-1:0] req_size,
   output logic                      done_valid,
   input  logic                      done_ready,
   output fhl_pkg::rsp_type          done_rsp
);
   import fhl_pkg::*;

   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int MW = KEY_BITS + SIZE_W + RW;

   logic [MW-1:0] mem [ENTRIES];
   logic [MW-1:0] rdq_ff;
   logic          rd_en;
   logic [RW-1:0] rd_addr;
   logic          mem_we;
   logic [MW-1:0] mem_wd;

   state_type state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic                isfz_ff, isfz_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  frozen_ff, frozen_in;
   logic [CW-1:0]       dyn_cnt_ff, dyn_cnt_in;
   logic [CW-1:0]       vld_cnt_ff, vld_cnt_in;
   logic [RW-1:0]       slot_ff, slot_in;
   logic [RW-1:0]       r_ff, r_in;
   logic [RW-1:0]       free_ff, free_in;
   logic [CW-1:0]       f_ff, f_in;
   logic                hit_ff, hit_in;
   logic                fhit_ff, fhit_in;
   logic                ins_ff, ins_in;
   logic [EVC_W-1:0]    evc_ff, evc_in;
   logic [CW-1:0]       ic_ff, ic_in;
   logic                pvld_ff, pvld_in;
   logic [RW-1:0]       paddr_ff, paddr_in;

   logic [KEY_BITS-1:0] e_key;
   logic [SIZE_W-1:0]   e_bytes;
   logic [RW-1:0]       e_rank;
   logic                e_v, e_fr, e_dyn, last, sweep, need_ev;
   logic [RW-1:0]       free_idx;
   logic [31:0]         vc32, fc32;

   assign e_key   = rdq_ff[MW-1 -: KEY_BITS];
   assign e_bytes = rdq_ff[RW +: SIZE_W];
   assign e_rank  = rdq_ff[RW-1:0];
   assign e_v     = valid_ff[paddr_ff];
   assign e_fr    = frozen_ff[paddr_ff];
   assign e_dyn   = e_v && !e_fr;
   assign last    = pvld_ff && (paddr_ff == RW'(ENTRIES - 1));
   assign vc32    = 32'(vld_cnt_ff);
   assign fc32    = 32'(cfg.frozen_count);
   assign need_ev = ((ACC_W'(occ_ff) + ACC_W'(size_ff)) > ACC_W'(cfg.capacity)) ||
                    (vld_cnt_ff == CW'(ENTRIES));

   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = RW'(i);
      end
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      size_in    = size_ff;
      acc_in     = acc_ff;
      occ_in     = occ_ff;
      isfz_in    = isfz_ff;
      valid_in   = valid_ff;
      frozen_in  = frozen_ff;
      dyn_cnt_in = dyn_cnt_ff;
      vld_cnt_in = vld_cnt_ff;
      slot_in    = slot_ff;
      r_in       = r_ff;
      free_in    = free_ff;
      f_in       = f_ff;
      hit_in     = hit_ff;
      fhit_in    = fhit_ff;
      ins_in     = ins_ff;
      evc_in     = evc_ff;
      ic_in      = ic_ff;
      mem_we     = 1'b0;
      mem_wd     = rdq_ff;
      rd_en      = 1'b0;
      rd_addr    = ic_ff[RW-1:0];
      sweep      = (state_ff == S_LOOK) || (state_ff == S_PROMO) ||
                   (state_ff == S_EVICT) || (state_ff == S_INS) || (state_ff == S_FRZ);
      // issue one read per cycle through the whole memory
      if (sweep && (ic_ff < CW'(ENTRIES))) begin
         rd_en = 1'b1;
         ic_in = ic_ff + CW'(1);
      end
      pvld_in  = rd_en;
      paddr_in = rd_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in  = req_key;
               size_in = req_size;
               hit_in  = 1'b0;
               fhit_in = 1'b0;
               ins_in  = 1'b0;
               evc_in  = '0;
               if (!isfz_ff && (acc_ff != '1)) acc_in = acc_ff + ACC_W'(1);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (pvld_ff && e_v && (e_key == key_ff)) begin
               hit_in  = 1'b1;
               slot_in = paddr_ff;
               r_in    = e_rank;
               if (e_fr) begin
                  fhit_in  = 1'b1;
                  state_in = S_FRZCHK;
               end else begin
                  state_in = S_PROMO;
               end
            end else if (last) begin
               state_in = (size_ff > cfg.capacity) ? S_FRZCHK : S_EVCHK;
            end
         end
         S_PROMO: begin
            if (pvld_ff && e_dyn) begin
               if (paddr_ff == slot_ff) begin
                  mem_we = 1'b1;
                  mem_wd = {e_key, e_bytes, RW'(0)};
               end else if (e_rank < r_ff) begin
                  mem_we = 1'b1;
                  mem_wd = {e_key, e_bytes, e_rank + RW'(1)};
               end
            end
            if (last) state_in = S_FRZCHK;
         end
         S_EVCHK: begin
            if (need_ev) begin
               state_in = (dyn_cnt_ff == '0) ? S_FRZCHK : S_EVICT;
            end else begin
               free_in  = free_idx;
               state_in = S_INS;
            end
         end
         S_EVICT: begin
            if (pvld_ff && e_dyn && (e_rank == RW'(dyn_cnt_ff - CW'(1)))) begin
               valid_in[paddr_ff] = 1'b0;
               occ_in     = occ_ff - OCC_W'(e_bytes);
               dyn_cnt_in = dyn_cnt_ff - CW'(1);
               vld_cnt_in = vld_cnt_ff - CW'(1);
               if (evc_ff != '1) evc_in = evc_ff + EVC_W'(1);
               state_in   = S_EVCHK;
            end else if (last) begin
               state_in = S_FRZCHK;
            end
         end
         S_INS: begin
            if (pvld_ff) begin
               if (paddr_ff == free_ff) begin
                  mem_we = 1'b1;
                  mem_wd = {key_ff, size_ff, RW'(0)};
               end else if (e_dyn) begin
                  mem_we = 1'b1;
                  mem_wd = {e_key, e_bytes, e_rank + RW'(1)};
               end
            end
            if (last) begin
               valid_in[free_ff]  = 1'b1;
               frozen_in[free_ff] = 1'b0;
               occ_in     = occ_ff + OCC_W'(size_ff);
               dyn_cnt_in = dyn_cnt_ff + CW'(1);
               vld_cnt_in = vld_cnt_ff + CW'(1);
               ins_in     = 1'b1;
               state_in   = S_FRZCHK;
            end
         end
         S_FRZCHK: begin
            if (!isfz_ff && (acc_ff >= {1'b0, cfg.capacity, 1'b0}) && (vc32 >= fc32)) begin
               if (vc32 == 32'd0) f_in = '0;
               else if (fc32 > vc32 - 32'd1) f_in = CW'(vc32 - 32'd1);
               else f_in = CW'(fc32);
               state_in = S_FRZ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FRZ: begin
            if (pvld_ff && e_dyn) begin
               if (CW'(e_rank) < f_ff) begin
                  frozen_in[paddr_ff] = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  mem_wd = {e_key, e_bytes, RW'(CW'(e_rank) - f_ff)};
               end
            end
            if (last) begin
               isfz_in    = 1'b1;
               dyn_cnt_in = dyn_cnt_ff - f_ff;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (done_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // restart the sweep on every state change; drop reads in flight
      if (state_in != state_ff) begin
         ic_in   = '0;
         pvld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[paddr_ff] <= mem_wd;
      if (rd_en) rdq_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         acc_ff     <= '0;
         occ_ff     <= '0;
         isfz_ff    <= 1'b0;
         valid_ff   <= '0;
         frozen_ff  <= '0;
         dyn_cnt_ff <= '0;
         vld_cnt_ff <= '0;
         ic_ff      <= '0;
         pvld_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         occ_ff     <= occ_in;
         isfz_ff    <= isfz_in;
         valid_ff   <= valid_in;
         frozen_ff  <= frozen_in;
         dyn_cnt_ff <= dyn_cnt_in;
         vld_cnt_ff <= vld_cnt_in;
         ic_ff      <= ic_in;
         pvld_ff    <= pvld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      size_ff  <= size_in;
      slot_ff  <= slot_in;
      r_ff     <= r_in;
      free_ff  <= free_in;
      f_ff     <= f_in;
      hit_ff   <= hit_in;
      fhit_ff  <= fhit_in;
      ins_ff   <= ins_in;
      evc_ff   <= evc_in;
      paddr_ff <= paddr_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   always_comb begin
      done_rsp.hit           = hit_ff;
      done_rsp.frozen_hit    = fhit_ff;
      done_rsp.inserted      = ins_ff;
      done_rsp.evicted_count = evc_ff;
      done_rsp.frozen_mode   = isfz_ff;
   end

endmodule

### rtl/frozen_hot_lru_replacement.sv
// A request is taken only while the engine is idle. Its lookup reads the
// entry memory, which has one read and one write port, one entry per cycle;
// each eviction and the insert, if any, add one more sweep of the memory,
// and the request that builds the frozen region makes one more sweep.
// A finished word waits in the output register, so the next request is taken
// while it is still unread. Configuration registers are to be written only
// while the block is idle; the user is bound to this, the block does not enforce it.
module frozen_hot_lru_replacement #(
   parameter int ENTRIES  = fhl_pkg::FHL_ENTRIES,
   parameter int KEY_BITS = fhl_pkg::FHL_KEY_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fhl_pkg::REQ_DATA_W-1:0]  req_tdata,  // object_id, object_size
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit, frozen_hit, inserted, evicted_count, frozen_mode, zero fill
   output logic [fhl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [fhl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fhl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fhl_pkg::*;

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   rsp_type done_rsp;
   logic    rsp_vld_ff;
   logic    done_valid, done_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity     <= CAP_RESET;
         cfg_ff.frozen_count <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAPACITY:     cfg_ff.capacity     <= csr_wdata[CAP_W-1:0];
            CSR_FROZEN_COUNT: cfg_ff.frozen_count <= csr_wdata[FC_W-1:0];
            default: ;
         endcase
      end
   end

   fhl_engine #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .req_size   (req_tdata[ID_W +: SIZE_W]),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_rsp   (done_rsp)
   );

   assign done_ready = !rsp_vld_ff || rsp_tready;

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (done_valid && done_ready) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) rsp_ff <= done_rsp;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_ff};

endmodule

### rtl/fhl_checker.sv
// Port-level checks of the result stream, bound to the top level.
module fhl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fhl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fhl_pkg::*;

   logic fz_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fz_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[10]) begin
         fz_seen_ff <= 1'b1;
      end
   end

   a_fhit_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("frozen hit without hit");

   a_hit_no_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[2] && (rsp_tdata[9:3] == 7'd0))
      else $error("hit word reports insert or evictions");

   a_frozen_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fz_seen_ff |-> rsp_tdata[10])
      else $error("frozen mode dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");

endmodule

bind frozen_hot_lru_replacement fhl_checker u_fhl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
